### sv/mcr_pkg.sv
// ----------------------------------------------------------------------------
// mcr_pkg: shared types and constants of the MCTP control responder
// Payload structs, command and status groups between the controller and the
// datapath, protocol codes, and the response byte lookup.
// ----------------------------------------------------------------------------
package mcr_pkg;

    localparam int BYTE_W    = 8;
    localparam int UUID_W    = 64;
    localparam int CFG_IDX_W = 8;
    localparam int SEEN_W    = 3;
    localparam int IDX_W     = 5;

    // Register indexes of the configuration port
    localparam logic [CFG_IDX_W-1:0] CFG_UUID_UPPER = 8'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_UUID_LOWER = 8'd1;

    // Request lengths
    localparam logic [SEEN_W-1:0] HDR_LEN     = 3'd3;
    localparam logic [SEEN_W-1:0] SET_EID_LEN = 3'd5;

    // Request byte positions that get captured
    localparam logic [SEEN_W-1:0] POS_FIRST  = 3'd0;
    localparam logic [SEEN_W-1:0] POS_HEADER = 3'd1;
    localparam logic [SEEN_W-1:0] POS_CMD    = 3'd2;
    localparam logic [SEEN_W-1:0] POS_EID    = 3'd4;

    localparam logic [BYTE_W-1:0] MSG_TYPE_CONTROL = 8'h00;
    localparam int                RQ_BIT           = 7;

    localparam logic [BYTE_W-1:0] CMD_SET_EID   = 8'h01;
    localparam logic [BYTE_W-1:0] CMD_GET_EID   = 8'h02;
    localparam logic [BYTE_W-1:0] CMD_GET_UUID  = 8'h03;
    localparam logic [BYTE_W-1:0] CMD_GET_TYPES = 8'h05;

    localparam logic [BYTE_W-1:0] CC_SUCCESS     = 8'h00;
    localparam logic [BYTE_W-1:0] CC_BAD_LENGTH  = 8'h03;
    localparam logic [BYTE_W-1:0] CC_UNSUPPORTED = 8'h05;

    localparam logic [BYTE_W-1:0] TYPES_COUNT = 8'h01;

    // Response byte positions
    localparam logic [IDX_W-1:0] RSP_TYPE   = 5'd0;
    localparam logic [IDX_W-1:0] RSP_HEADER = 5'd1;
    localparam logic [IDX_W-1:0] RSP_CMD    = 5'd2;
    localparam logic [IDX_W-1:0] RSP_CODE   = 5'd3;
    localparam logic [IDX_W-1:0] RSP_DATA0  = 5'd4;
    localparam logic [IDX_W-1:0] RSP_DATA1  = 5'd5;
    localparam logic [IDX_W-1:0] RSP_UUID_LAST_UPPER = 5'd11;

    typedef struct packed {
        logic [BYTE_W-1:0] req_byte;
        logic              req_last;
    } req_t;

    typedef struct packed {
        logic [BYTE_W-1:0] resp_byte;
        logic              resp_last;
    } resp_t;

    typedef enum logic [2:0] {
        K_GET_EID,
        K_SET_OK,
        K_SET_BAD,
        K_UUID,
        K_TYPES,
        K_UNSUP
    } rsp_kind_t;

    // Controller to datapath
    typedef struct packed {
        logic capture;   // take the request byte on the input
        logic decide;    // classify the finished request
        logic load;      // move the next response byte to the output
    } mcr_cmd_t;

    // Datapath to controller
    typedef struct packed {
        logic respond;   // finished request calls for a response
        logic out_free;  // output register can take a byte this cycle
        logic final_idx; // byte being loaded is the last of the response
    } mcr_status_t;

    function automatic logic [IDX_W-1:0] last_index(input rsp_kind_t kind);
        logic [IDX_W-1:0] n;
        case (kind)
            K_GET_EID: n = 5'd6;
            K_SET_OK:  n = 5'd6;
            K_UUID:    n = 5'd19;
            K_TYPES:   n = 5'd5;
            default:   n = RSP_CODE;
        endcase
        return n;
    endfunction

    function automatic logic [BYTE_W-1:0] completion(input rsp_kind_t kind);
        logic [BYTE_W-1:0] cc;
        case (kind)
            K_SET_BAD: cc = CC_BAD_LENGTH;
            K_UNSUP:   cc = CC_UNSUPPORTED;
            default:   cc = CC_SUCCESS;
        endcase
        return cc;
    endfunction

endpackage

### sv/mcr_ctrl.sv
// ----------------------------------------------------------------------------
// mcr_ctrl: sequencing state machine of the MCTP control responder
// Takes request bytes, hands a finished request to the datapath for
// classification, then paces the response bytes into the output register.
// ----------------------------------------------------------------------------
module mcr_ctrl
    import mcr_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        req_valid,
    input  logic        req_last,
    input  mcr_status_t status,
    output logic        req_stall,
    output mcr_cmd_t    cmd
);

    typedef enum logic [2:0] {
        ST_IDLE   = 3'b001,
        ST_DECIDE = 3'b010,
        ST_SEND   = 3'b100
    } state_t;

    state_t state_reg;
    state_t state_next;

    always_comb
    begin
        state_next  = state_reg;
        req_stall   = 1'b1;
        cmd         = '0;
        case (state_reg)
            ST_IDLE:
            begin
                req_stall   = 1'b0;
                cmd.capture = req_valid;
                if (req_valid && req_last)
                begin
                    state_next = ST_DECIDE;
                end
            end
            ST_DECIDE:
            begin
                cmd.decide = 1'b1;
                state_next = status.respond ? ST_SEND : ST_IDLE;
            end
            ST_SEND:
            begin
                // advance one byte whenever the output slot frees up
                if (status.out_free)
                begin
                    cmd.load = 1'b1;
                    if (status.final_idx)
                    begin
                        state_next = ST_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

### sv/mcr_dp.sv
// ----------------------------------------------------------------------------
// mcr_dp: datapath of the MCTP control responder
// Holds the endpoint ID, UUID registers and captured request bytes, builds
// response bytes by position and keeps the registered output stage.
// ----------------------------------------------------------------------------
module mcr_dp
    import mcr_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  mcr_cmd_t             cmd,
    input  req_t                 req,
    input  logic                 resp_stall,
    input  logic                 cfg_valid,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [UUID_W-1:0]    cfg_data,
    output mcr_status_t          status,
    output logic                 resp_valid,
    output resp_t                resp
);

    logic [BYTE_W-1:0] eid_reg;
    logic [SEEN_W-1:0] seen_reg;
    logic [SEEN_W-1:0] len_reg;
    logic [BYTE_W-1:0] first_reg;
    logic [BYTE_W-1:0] header_reg;
    logic [BYTE_W-1:0] cmd_reg;
    logic [BYTE_W-1:0] req_eid_reg;
    logic [UUID_W-1:0] uuid_upper_reg;
    logic [UUID_W-1:0] uuid_lower_reg;
    rsp_kind_t         kind_reg;
    logic [IDX_W-1:0]  idx_reg;
    logic              out_valid_reg;
    resp_t             out_reg;

    logic [SEEN_W-1:0]   seen_sat;
    logic                respond_c;
    rsp_kind_t           kind_c;
    logic [BYTE_W-1:0]   byte_c;
    logic [2*UUID_W-1:0] uuid_all;
    logic [3:0]          uuid_pos;

    assign seen_sat = (seen_reg < SET_EID_LEN) ? seen_reg + 3'd1 : seen_reg;

    // Classify the finished request
    assign respond_c = (len_reg >= HDR_LEN)
                    && (first_reg[BYTE_W-2:0] == MSG_TYPE_CONTROL[BYTE_W-2:0])
                    && header_reg[RQ_BIT];

    always_comb
    begin
        case (cmd_reg)
            CMD_GET_EID:   kind_c = K_GET_EID;
            CMD_SET_EID:   kind_c = (len_reg >= SET_EID_LEN) ? K_SET_OK : K_SET_BAD;
            CMD_GET_UUID:  kind_c = K_UUID;
            CMD_GET_TYPES: kind_c = K_TYPES;
            default:       kind_c = K_UNSUP;
        endcase
    end

    // Response byte at the current position; UUID bytes sit at 4 to 19
    assign uuid_all = {uuid_upper_reg, uuid_lower_reg};
    assign uuid_pos = idx_reg[3:0] - RSP_DATA0[3:0];

    always_comb
    begin
        byte_c = '0;
        case (idx_reg)
            RSP_TYPE:   byte_c = MSG_TYPE_CONTROL;
            RSP_HEADER: byte_c = {1'b0, header_reg[BYTE_W-2:0]};
            RSP_CMD:    byte_c = cmd_reg;
            RSP_CODE:   byte_c = completion(kind_reg);
            default:
            begin
                case (kind_reg)
                    K_GET_EID: byte_c = (idx_reg == RSP_DATA0) ? eid_reg : '0;
                    K_SET_OK:  byte_c = (idx_reg == RSP_DATA1) ? eid_reg : '0;
                    K_TYPES:   byte_c = (idx_reg == RSP_DATA0) ? TYPES_COUNT
                                                               : MSG_TYPE_CONTROL;
                    K_UUID:    byte_c = uuid_all[2*UUID_W-1 - BYTE_W*uuid_pos -: BYTE_W];
                    default:   byte_c = '0;
                endcase
            end
        endcase
    end

    assign status.respond   = respond_c;
    assign status.out_free  = !out_valid_reg || !resp_stall;
    assign status.final_idx = (idx_reg == last_index(kind_reg));

    assign resp_valid = out_valid_reg;
    assign resp       = out_reg;

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            eid_reg        <= '0;
            seen_reg       <= '0;
            len_reg        <= '0;
            first_reg      <= '0;
            header_reg     <= '0;
            cmd_reg        <= '0;
            req_eid_reg    <= '0;
            uuid_upper_reg <= '0;
            uuid_lower_reg <= '0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            if (cfg_valid && cfg_index == CFG_UUID_UPPER)
            begin
                uuid_upper_reg <= cfg_data;
            end
            if (cfg_valid && cfg_index == CFG_UUID_LOWER)
            begin
                uuid_lower_reg <= cfg_data;
            end
            if (cmd.capture)
            begin
                case (seen_reg)
                    POS_FIRST:  first_reg   <= req.req_byte;
                    POS_HEADER: header_reg  <= req.req_byte;
                    POS_CMD:    cmd_reg     <= req.req_byte;
                    POS_EID:    req_eid_reg <= req.req_byte;
                    default:    ;
                endcase
                if (req.req_last)
                begin
                    seen_reg <= '0;
                    len_reg  <= seen_sat;
                end
                else
                begin
                    seen_reg <= seen_sat;
                end
            end
            if (cmd.decide && respond_c && kind_c == K_SET_OK)
            begin
                eid_reg <= req_eid_reg;
            end
            if (cmd.load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!resp_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        if (cmd.decide)
        begin
            kind_reg <= kind_c;
            idx_reg  <= '0;
        end
        if (cmd.load)
        begin
            out_reg.resp_byte <= byte_c;
            out_reg.resp_last <= status.final_idx;
            idx_reg           <= idx_reg + 5'd1;
        end
    end

endmodule

### sv/mctp_control_responder.sv
// ----------------------------------------------------------------------------
// mctp_control_responder: MCTP control message responder
// Answers Set/Get Endpoint ID, Get Endpoint UUID and Get Message Type
// Support requests, one byte per handshake on each side.
// ----------------------------------------------------------------------------
// Usage:
//   Request channel (req_valid / req_stall / req): one request byte per
//   accepted request, req_last on the final byte. Bytes are taken one per
//   cycle while no response is being built.
//   Response channel (resp_valid / resp_stall / resp): the response bytes,
//   resp_last on the final one. Malformed requests (too short, not a
//   control message, or the request bit clear) produce no response.
//   Configuration channel (cfg_valid / cfg_ready / cfg_index / cfg_data):
//   index 0 loads the upper UUID bytes, index 1 the lower; other indexes are
//   ignored. cfg_ready is always high.
// Timing:
//   Non-final bytes: one per cycle. After the final byte the controller
//   classifies the request in its decide state, then, in its send state,
//   loads one response byte per cycle into the output register (4 to 20
//   bytes) whenever that register is free. The input reopens as soon as
//   the last response byte is loaded, while it may still wait in the
//   output register.
//   A stalled receiver holds the output register and pauses the sequencer.
// Reset: clears the endpoint ID, UUID, byte counter and output valid.
// ----------------------------------------------------------------------------
module mctp_control_responder
    import mcr_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 req_valid,
    output logic                 req_stall,
    input  req_t                 req,
    output logic                 resp_valid,
    input  logic                 resp_stall,
    output resp_t                resp,
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [UUID_W-1:0]    cfg_data
);

    mcr_cmd_t    cmd;
    mcr_status_t status;

    // Register writes are taken in any cycle
    assign cfg_ready = 1'b1;

    // Sequencer: idle / classify / send
    mcr_ctrl u_ctrl
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_last  (req.req_last),
        .status    (status),
        .req_stall (req_stall),
        .cmd       (cmd)
    );

    // Captured request, endpoint state and output register
    mcr_dp u_dp
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd        (cmd),
        .req        (req),
        .resp_stall (resp_stall),
        .cfg_valid  (cfg_valid),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .status     (status),
        .resp_valid (resp_valid),
        .resp       (resp)
    );

endmodule

### sv/mcr_checker.sv
// ----------------------------------------------------------------------------
// mcr_checker: port-level checks of the MCTP control responder
// Watches the request and response channels over time.
// ----------------------------------------------------------------------------
module mcr_checker
    import mcr_pkg::*;
(
    input logic  clk,
    input logic  rst_n,
    input logic  req_valid,
    input logic  req_stall,
    input req_t  req,
    input logic  resp_valid,
    input logic  resp_stall,
    input resp_t resp
);

    // Hold a stalled response
    a_resp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        resp_valid && resp_stall |=> resp_valid && $stable(resp))
        else $error("stalled response byte dropped or changed");

    // Keep taking bytes inside a request
    a_req_open: assert property (@(posedge clk) disable iff (!rst_n)
        req_valid && !req_stall && !req.req_last |=> !req_stall)
        else $error("input closed in the middle of a request");

    // Close the input after the final request byte
    a_req_close: assert property (@(posedge clk) disable iff (!rst_n)
        req_valid && !req_stall && req.req_last |=> req_stall)
        else $error("input open right after a final request byte");

    // Take no request while a response is mid-stream
    a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
        resp_valid && !resp.resp_last |-> req_stall)
        else $error("request taken during a response");

endmodule

bind mctp_control_responder mcr_checker u_mcr_checker
(
    .clk        (clk),
    .rst_n      (rst_n),
    .req_valid  (req_valid),
    .req_stall  (req_stall),
    .req        (req),
    .resp_valid (resp_valid),
    .resp_stall (resp_stall),
    .resp       (resp)
);

### tb/sv/mcr_reply_checker.sv
// ----------------------------------------------------------------------------
// mcr_reply_checker: response predictor and checker for the control responder
// Watches the request, response and configuration channels, keeps its own
// copy of the endpoint state and UUID, and compares each response byte.
// ----------------------------------------------------------------------------
module mcr_reply_checker
    import mcr_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 req_valid,
    input  logic                 req_stall,
    input  req_t                 req,
    input  logic                 resp_valid,
    input  logic                 resp_stall,
    input  resp_t                resp,
    input  logic                 cfg_valid,
    input  logic                 cfg_ready,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [UUID_W-1:0]    cfg_data,
    output int                   mismatches,
    output int                   replies_due
);

    localparam logic [BYTE_W-1:0] TYPE_MASK   = 8'h7F;
    localparam int                MAX_REPLY   = 20;

    logic [UUID_W-1:0] uuid_hi;
    logic [UUID_W-1:0] uuid_lo;
    logic [BYTE_W-1:0] eid;
    logic [BYTE_W-1:0] first_b;
    logic [BYTE_W-1:0] header_b;
    logic [BYTE_W-1:0] cmd_b;
    logic [BYTE_W-1:0] new_eid;
    logic [SEEN_W-1:0] seen;
    resp_t             reply_q[$];
    resp_t             want;

    // Capture one request byte; on the final one, queue the response bytes.
    task automatic absorb_request(input req_t r);
        logic [BYTE_W-1:0] rb[MAX_REPLY];
        logic [BYTE_W-1:0] code;
        logic [SEEN_W-1:0] len;
        int                n;
        resp_t             item;
        case (seen)
            POS_FIRST:  first_b  = r.req_byte;
            POS_HEADER: header_b = r.req_byte;
            POS_CMD:    cmd_b    = r.req_byte;
            POS_EID:    new_eid  = r.req_byte;
            default:    ;
        endcase
        if (seen < SET_EID_LEN)
            seen = seen + 1'b1;
        if (!r.req_last)
            return;
        len  = seen;
        seen = '0;
        // Drop short, non-control and non-request messages silently
        if (len < HDR_LEN || (first_b & TYPE_MASK) != MSG_TYPE_CONTROL
            || !header_b[RQ_BIT])
            return;
        code = CC_SUCCESS;
        n    = 4;
        case (cmd_b)
            CMD_GET_EID:
            begin
                rb[4] = eid;
                rb[5] = '0;
                rb[6] = '0;
                n     = 7;
            end
            CMD_SET_EID:
            begin
                if (len < SET_EID_LEN)
                    code = CC_BAD_LENGTH;
                else
                begin
                    eid   = new_eid;
                    rb[4] = '0;
                    rb[5] = eid;
                    rb[6] = '0;
                    n     = 7;
                end
            end
            CMD_GET_UUID:
            begin
                for (int i = 0; i < 8; i++)
                begin
                    rb[4 + i]  = uuid_hi[UUID_W-1-BYTE_W*i -: BYTE_W];
                    rb[12 + i] = uuid_lo[UUID_W-1-BYTE_W*i -: BYTE_W];
                end
                n = MAX_REPLY;
            end
            CMD_GET_TYPES:
            begin
                rb[4] = TYPES_COUNT;
                rb[5] = MSG_TYPE_CONTROL;
                n     = 6;
            end
            default:
                code = CC_UNSUPPORTED;
        endcase
        rb[0] = MSG_TYPE_CONTROL;
        rb[1] = {1'b0, header_b[RQ_BIT-1:0]};
        rb[2] = cmd_b;
        rb[3] = code;
        for (int i = 0; i < n; i++)
        begin
            item.resp_byte = rb[i];
            item.resp_last = (i == n - 1);
            reply_q.insert(reply_q.size(), item);
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            uuid_hi  = '0;
            uuid_lo  = '0;
            eid      = '0;
            first_b  = '0;
            header_b = '0;
            cmd_b    = '0;
            new_eid  = '0;
            seen     = '0;
            reply_q.delete();
        end
        else
        begin
            if (resp_valid && !resp_stall)
            begin
                if (reply_q.size() == 0)
                begin
                    $error("resp_byte: expected none, got %02h (resp_last %0b)",
                           resp.resp_byte, resp.resp_last);
                    mismatches++;
                end
                else
                begin
                    want = reply_q.pop_front();
                    if (resp.resp_byte !== want.resp_byte)
                    begin
                        $error("resp_byte: expected %02h, got %02h",
                               want.resp_byte, resp.resp_byte);
                        mismatches++;
                    end
                    if (resp.resp_last !== want.resp_last)
                    begin
                        $error("resp_last: expected %0b, got %0b",
                               want.resp_last, resp.resp_last);
                        mismatches++;
                    end
                end
            end
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    CFG_UUID_UPPER: uuid_hi = cfg_data;
                    CFG_UUID_LOWER: uuid_lo = cfg_data;
                    default:        ;
                endcase
            end
            if (req_valid && !req_stall)
                absorb_request(req);
        end
        replies_due = reply_q.size();
    end

endmodule

### tb/sv/tb.sv
// ----------------------------------------------------------------------------
// tb: stimulus and verdict for the MCTP control responder
// Sends directed and random control request messages under random idling on
// both channels, reloads the UUID between phases, and reports the outcome
// from the failure count of the reply checker.
// ----------------------------------------------------------------------------
module tb
    import mcr_pkg::*;
();

    // Any index other than the two UUID halves must be ignored
    localparam logic [CFG_IDX_W-1:0] CFG_UNUSED_IDX = 8'hFF;

    localparam int HOLD_CYCLES    = 80;    // long receiver hold-off
    localparam int SETTLE_CYCLES  = 8;     // classify state plus margin
    localparam int WATCHDOG_LIMIT = 2000;  // cycles with no handshake at all

    typedef logic [BYTE_W-1:0] octets_t[$];

    logic                 clk;
    logic                 rst_n;
    logic                 req_valid;
    logic                 req_stall;
    req_t                 req;
    logic                 resp_valid;
    logic                 resp_stall;
    resp_t                resp;
    logic                 cfg_valid;
    logic                 cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [UUID_W-1:0]    cfg_data;

    int mismatches;
    int replies_due;
    int bytes_sent;
    int idle_cycles = 0;
    bit quiet;        // set for the final stretch: no idling on either side
    bit hold_off_req; // ask the receiver for one long stall

    mctp_control_responder uut (
        .clk        (clk),
        .rst_n      (rst_n),
        .req_valid  (req_valid),
        .req_stall  (req_stall),
        .req        (req),
        .resp_valid (resp_valid),
        .resp_stall (resp_stall),
        .resp       (resp),
        .cfg_valid  (cfg_valid),
        .cfg_ready  (cfg_ready),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data)
    );

    mcr_reply_checker checker_i (
        .clk         (clk),
        .rst_n       (rst_n),
        .req_valid   (req_valid),
        .req_stall   (req_stall),
        .req         (req),
        .resp_valid  (resp_valid),
        .resp_stall  (resp_stall),
        .resp        (resp),
        .cfg_valid   (cfg_valid),
        .cfg_ready   (cfg_ready),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .mismatches  (mismatches),
        .replies_due (replies_due)
    );

    initial
        clk = 1'b0;

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    // Offer one request; optionally idle first. Hold the payload until taken.
    task automatic send_byte(input logic [BYTE_W-1:0] b, input logic last);
        if (!quiet && $urandom_range(0, 5) == 0)
        begin
            req_valid <= 1'b0;
            repeat ($urandom_range(1, 16)) @(posedge clk);
        end
        req_valid <= 1'b1;
        req       <= '{req_byte: b, req_last: last};
        do
            @(posedge clk);
        while (req_stall);
        bytes_sent++;
    endtask

    // Send a whole request message, marking the final byte.
    task automatic send_request(input octets_t msg);
        for (int i = 0; i < msg.size(); i++)
            send_byte(msg[i], i == msg.size() - 1);
    endtask

    // Build one random request message. Most are well formed with random
    // content so they get past the header checks; the rest are noise.
    task automatic random_request();
        octets_t           msg;
        logic [BYTE_W-1:0] cmd;
        logic              bit_hi;
        int                len;
        if ($urandom_range(0, 9) < 8)
        begin
            case ($urandom_range(0, 4))
                0:       cmd = CMD_SET_EID;
                1:       cmd = CMD_GET_EID;
                2:       cmd = CMD_GET_UUID;
                3:       cmd = CMD_GET_TYPES;
                default: cmd = 8'($urandom_range(0, 255));
            endcase
            // Set EID sometimes one byte short, everything else sometimes long
            len    = (cmd == CMD_SET_EID) ? $urandom_range(4, 7) : $urandom_range(3, 6);
            bit_hi = 1'($urandom_range(0, 1));
            msg.insert(msg.size(), {bit_hi, MSG_TYPE_CONTROL[RQ_BIT-1:0]});
            msg.insert(msg.size(), {1'b1, 7'($urandom_range(0, 127))});
            msg.insert(msg.size(), cmd);
            while (msg.size() < len)
                msg.insert(msg.size(), 8'($urandom_range(0, 255)));
        end
        else
        begin
            len = $urandom_range(1, 7);
            repeat (len)
                msg.insert(msg.size(), 8'($urandom_range(0, 255)));
        end
        send_request(msg);
    endtask

    // Write both UUID halves and one unused index, valid held high throughout.
    task automatic load_uuid(input logic [UUID_W-1:0] hi, input logic [UUID_W-1:0] lo);
        cfg_valid <= 1'b1;
        cfg_index <= CFG_UUID_UPPER;
        cfg_data  <= hi;
        do
            @(posedge clk);
        while (!cfg_ready);
        cfg_index <= CFG_UUID_LOWER;
        cfg_data  <= lo;
        do
            @(posedge clk);
        while (!cfg_ready);
        cfg_index <= CFG_UNUSED_IDX;
        cfg_data  <= {$urandom, $urandom};
        do
            @(posedge clk);
        while (!cfg_ready);
        cfg_valid <= 1'b0;
    endtask

    // Drop valid, drain every expected response, then give a silent
    // request time to finish classifying before touching the registers.
    // Advance the clock first so the checker has queued the final request.
    task automatic settle();
        req_valid <= 1'b0;
        @(posedge clk);
        while (replies_due != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // Receiver: random stall bursts, open stretches, and one long hold-off
    // on request so the block backs up into its input.
    initial
    begin
        resp_stall = 1'b0;
        @(posedge rst_n);
        forever
        begin
            if (hold_off_req)
            begin
                hold_off_req = 1'b0;
                resp_stall <= 1'b1;
                repeat (HOLD_CYCLES) @(posedge clk);
            end
            else if (!quiet && $urandom_range(0, 3) == 0)
            begin
                resp_stall <= 1'b1;
                repeat ($urandom_range(1, 16)) @(posedge clk);
            end
            else
            begin
                resp_stall <= 1'b0;
                repeat ($urandom_range(1, 12)) @(posedge clk);
            end
        end
    end

    // Watchdog: end the run if no channel moves anything for too long.
    always @(posedge clk)
    begin
        if ((req_valid && !req_stall) || (resp_valid && !resp_stall)
            || (cfg_valid && cfg_ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("status: fail");
            $finish;
        end
    end

    initial
    begin
        rst_n        = 1'b0;
        req_valid    = 1'b0;
        req          = '0;
        cfg_valid    = 1'b0;
        cfg_index    = '0;
        cfg_data     = '0;
        quiet        = 1'b0;
        hold_off_req = 1'b0;
        bytes_sent   = 0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed part: all-ones upper half, mixed lower half
        load_uuid('1, 64'h0123_4567_89AB_CDEF);
        // Get EID at reset value; header with every bit set
        send_request({8'h00, 8'hFF, CMD_GET_EID});
        // Long Set EID to all ones, bit 7 of the type byte set (still control)
        send_request({8'h80, 8'hFF, CMD_SET_EID, 8'h00, 8'hFF, 8'h00});
        // Set EID one byte short: bad length, EID stays
        send_request({8'h00, 8'h80, CMD_SET_EID, 8'h00});
        send_request({8'h00, 8'h81, CMD_GET_UUID});
        send_request({8'h00, 8'h80, CMD_GET_TYPES});
        // Unsupported command
        send_request({8'h00, 8'h80, 8'hFF});
        // Silent cases: too short, not a control message, request bit clear
        send_request({8'h00});
        send_request({8'h01, 8'h80, CMD_GET_EID});
        send_request({8'h00, 8'h7F, CMD_GET_EID});

        // Random part, first setting: halves swapped to the other extremes
        settle();
        load_uuid('0, '1);
        while (bytes_sent < 55)
            random_request();

        // Second setting: random UUID, then back up the block with a burst
        // of UUID requests while the receiver holds off
        settle();
        load_uuid({$urandom, $urandom}, {$urandom, $urandom});
        quiet        = 1'b1;
        hold_off_req = 1'b1;
        repeat (6)
            send_request({8'h00, 8'h80, CMD_GET_UUID});
        quiet = 1'b0;
        while (bytes_sent < 100)
            random_request();

        // Final stretch with no idling on either side
        quiet = 1'b1;
        while (bytes_sent < 120)
            random_request();

        settle();
        if (mismatches == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule
